FILE: src/m3i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg: shared constants for the 3x3 matrix inverse
// Default element format and the singular threshold register layout.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned THR_WIDTH      = 31;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 31'd1;

endpackage

FILE: src/m3i_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_if: matrix and inverse word channels
// Valid/ready channels carrying one input matrix or one inverse result word.
// ----------------------------------------------------------------------------
interface m3i_mat_if #(
  parameter int unsigned DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    input  ready
  );
  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output ready
  );
endinterface

interface m3i_inv_if #(
  parameter int unsigned DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic                         invertible;

  modport source (
    output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, invertible,
    input  ready
  );
  modport sink (
    input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, invertible,
    output ready
  );
endinterface

FILE: src/m3i_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_div_lane: pipelined saturating divider lane
// Restoring division of a scaled adjugate magnitude by the determinant
// magnitude, one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module m3i_div_lane #(
  parameter int unsigned DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic [2*DATA_WIDTH+1+2*FRAC_BITS-1:0]    num_mag_i,
  input  logic [3*DATA_WIDTH+3-1:0]                det_mag_i,
  input  logic                                     neg_i,
  output logic signed [DATA_WIDTH-1:0]             res_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned NW   = 2*W + 1 + 2*FRAC_BITS;
  localparam int unsigned DETW = 3*W + 3;
  localparam int unsigned QB   = W + 1;
  localparam int unsigned XW   = (NW > DETW) ? NW : DETW;
  localparam logic [QB-1:0] LIM = QB'(1) << (W - 1);

  logic [DETW-1:0] rem_q [QB+1];
  logic [QB-1:0]   nlo_q [QB+1];
  logic [DETW-1:0] div_q [QB+1];
  logic [QB-1:0]   quo_q [QB+1];
  logic            neg_q [QB+1];
  logic            ovf_q [QB+1];

  logic [XW-1:0]   num_x, det_x;
  logic            ovf_d;
  logic [DETW-1:0] rem_d;
  logic [QB-1:0]   quo;
  logic signed [W-1:0] res_d, res_q;

  always_comb begin
    num_x = XW'(num_mag_i);
    det_x = XW'(det_mag_i);
    ovf_d = (num_x >> QB) >= det_x;
    rem_d = DETW'(num_x >> QB);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d;
      nlo_q[0] <= num_mag_i[QB-1:0];
      div_q[0] <= det_mag_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [DETW:0] trial, diff;
    logic          ge;

    always_comb begin
      trial = {rem_q[s], nlo_q[s][QB-1]};
      ge    = trial >= {1'b0, div_q[s]};
      diff  = trial - {1'b0, div_q[s]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? diff[DETW-1:0] : trial[DETW-1:0];
        nlo_q[s+1] <= nlo_q[s] << 1;
        div_q[s+1] <= div_q[s];
        quo_q[s+1] <= {quo_q[s][QB-2:0], ge};
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  always_comb begin
    quo = quo_q[QB];
    if (neg_q[QB]) begin
      if (ovf_q[QB] || quo > LIM) begin
        res_d = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_d = -$signed(quo[W-1:0]);
      end
    end else begin
      if (ovf_q[QB] || quo >= LIM) begin
        res_d = {1'b0, {(W-1){1'b1}}};
      end else begin
        res_d = $signed(quo[W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: src/matrix3x3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse: streaming 3x3 fixed-point matrix inverse
// Adjugate and exact determinant, nine divider lanes, merged result word.
// ----------------------------------------------------------------------------
// The block accepts one matrix every clock cycle while its skid register is
// empty and returns its inverse: the cofactor product, adjugate, partial
// product, determinant and magnitude registers form the adjugate, the exact
// determinant and the singular test, nine parallel divider lanes then produce
// one quotient bit per stage, and the output register is loaded last. A skid
// register behind the output keeps the input ready independent of the output
// ready; the pipeline holds while the skid register is full.
module matrix3x3_inverse #(
  parameter int unsigned DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [m3i_pkg::THR_WIDTH-1:0]  cfg_wdata_i,
  m3i_mat_if.sink                        mat_i,
  m3i_inv_if.source                      inv_o
);

  localparam int unsigned W        = DATA_WIDTH;
  localparam int unsigned F        = FRAC_BITS;
  localparam int unsigned PW       = 2*W;
  localparam int unsigned AW       = 2*W + 1;
  localparam int unsigned DPW      = 2*W + 1;
  localparam int unsigned DETW     = 3*W + 3;
  localparam int unsigned NW       = AW + 2*F;
  localparam int unsigned TW       = m3i_pkg::THR_WIDTH;
  localparam int unsigned CMPW     = (DETW > TW + 2*F) ? DETW : TW + 2*F;
  localparam int unsigned LANE_LAT = W + 3;
  localparam int unsigned TOT      = 5 + LANE_LAT;

  localparam int unsigned OpX [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int unsigned OpY [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  logic [TW-1:0]         thr_q;
  logic                  en;
  logic [TOT-1:0]        v_q;
  logic [LANE_LAT-1:0]   sg_q;

  logic signed [W-1:0]    el [9];
  logic signed [PW-1:0]   pp_q [18];
  logic signed [W-1:0]    row1_q [3];
  logic signed [W-1:0]    row2_q [3];
  logic signed [AW-1:0]   adj2_q [9];
  logic signed [AW-1:0]   adj3_q [9];
  logic signed [AW-1:0]   adj4_q [9];
  logic signed [DPW-1:0]  plo_q [3];
  logic signed [DPW-1:0]  phi_q [3];
  logic signed [DETW-1:0] det_d, det_q;
  logic [DETW-1:0]        dmag_d, dmag_q;
  logic                   sing_d, sing5_q;
  logic [AW-1:0]          amag [9];
  logic [NW-1:0]          num_q [9];
  logic                   nneg_q [9];
  logic signed [W-1:0]    lane_res [9];

  logic signed [W-1:0]    nw_d [9];
  logic                   ninv_d;
  logic signed [W-1:0]    od_q [9];
  logic signed [W-1:0]    sd_q [9];
  logic                   oinv_q, sinv_q;
  logic                   ov_q, sv_q;
  logic                   pv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= m3i_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign en          = !sv_q;
  assign mat_i.ready = !sv_q;
  assign pv          = v_q[TOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[TOT-2:0], mat_i.valid};
    end
  end

  always_comb begin
    el[0] = mat_i.m00;
    el[1] = mat_i.m01;
    el[2] = mat_i.m02;
    el[3] = mat_i.m10;
    el[4] = mat_i.m11;
    el[5] = mat_i.m12;
    el[6] = mat_i.m20;
    el[7] = mat_i.m21;
    el[8] = mat_i.m22;
  end

  // Stages one and two: the cofactor products and the adjugate entries.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int n = 0; n < 18; n++) begin
        pp_q[n] <= el[OpX[n]] * el[OpY[n]];
      end
      for (int j = 0; j < 3; j++) begin
        row1_q[j] <= el[j];
        row2_q[j] <= row1_q[j];
      end
      for (int k = 0; k < 9; k++) begin
        adj2_q[k] <= AW'(pp_q[2*k]) - AW'(pp_q[2*k+1]);
        adj3_q[k] <= adj2_q[k];
        adj4_q[k] <= adj3_q[k];
      end
    end
  end

  // Stages three and four: first-row expansion of the determinant, split
  // into low and high partial products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo_q[j] <= row2_q[j] * $signed({1'b0, adj2_q[3*j][W-1:0]});
        phi_q[j] <= row2_q[j] * $signed(adj2_q[3*j][AW-1:W]);
      end
      det_q <= det_d;
    end
  end

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DETW'(phi_q[j]) <<< W) + DETW'(plo_q[j]);
    end
    dmag_d = det_q[DETW-1] ? DETW'(-det_q) : DETW'(det_q);
    sing_d = CMPW'(dmag_d) <= (CMPW'(thr_q) << (2*F));
    for (int k = 0; k < 9; k++) begin
      amag[k] = adj4_q[k][AW-1] ? AW'(-adj4_q[k]) : AW'(adj4_q[k]);
    end
  end

  // Stage five: magnitudes, result signs and the singular test.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dmag_q  <= dmag_d;
      sing5_q <= sing_d;
      sg_q    <= {sg_q[LANE_LAT-2:0], sing5_q};
      for (int k = 0; k < 9; k++) begin
        num_q[k]  <= NW'(amag[k]) << (2*F);
        nneg_q[k] <= adj4_q[k][AW-1] ^ det_q[DETW-1];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3i_div_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .num_mag_i (num_q[k]),
      .det_mag_i (dmag_q),
      .neg_i     (nneg_q[k]),
      .res_o     (lane_res[k])
    );
  end

  // Merge the lanes into one result word.
  always_comb begin
    ninv_d = !sg_q[LANE_LAT-1];
    for (int k = 0; k < 9; k++) begin
      nw_d[k] = sg_q[LANE_LAT-1] ? '0 : lane_res[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (inv_o.ready) begin
        sv_q <= 1'b0;
      end
    end else if (pv) begin
      if (!ov_q || inv_o.ready) begin
        ov_q <= 1'b1;
      end else begin
        sv_q <= 1'b1;
      end
    end else if (inv_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (inv_o.ready) begin
        od_q   <= sd_q;
        oinv_q <= sinv_q;
      end
    end else if (pv) begin
      if (!ov_q || inv_o.ready) begin
        od_q   <= nw_d;
        oinv_q <= ninv_d;
      end else begin
        sd_q   <= nw_d;
        sinv_q <= ninv_d;
      end
    end
  end

  assign inv_o.valid      = ov_q;
  assign inv_o.r00        = od_q[0];
  assign inv_o.r01        = od_q[1];
  assign inv_o.r02        = od_q[2];
  assign inv_o.r10        = od_q[3];
  assign inv_o.r11        = od_q[4];
  assign inv_o.r12        = od_q[5];
  assign inv_o.r20        = od_q[6];
  assign inv_o.r21        = od_q[7];
  assign inv_o.r22        = od_q[8];
  assign inv_o.invertible = oinv_q;

  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid register full while output register empty");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |=> $stable(v_q))
    else $error("pipeline moved while skid register full");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inv_o.valid && !inv_o.invertible) |->
      (inv_o.r00 == '0 && inv_o.r01 == '0 && inv_o.r02 == '0 &&
       inv_o.r10 == '0 && inv_o.r11 == '0 && inv_o.r12 == '0 &&
       inv_o.r20 == '0 && inv_o.r21 == '0 && inv_o.r22 == '0))
    else $error("singular word carries nonzero elements");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sv_q && pv && ov_q && !inv_o.ready) |=> sv_q)
    else $error("result word lost on output stall");

endmodule

FILE: tb/sv/matrix3x3_inverse_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_test: self-checking bench for the 3x3 matrix inverse
// Streams matrices through the block under changing sender and receiver idle
// rates and thresholds, predicts every inverse word with exact wide integer
// arithmetic and compares each returned word field by field.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_test;

  localparam int DW = m3i_pkg::DATA_WIDTH_DEF;
  localparam int FB = m3i_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = DW + 9;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [DW-1:0] elem_t;
  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    elem_t [8:0] r;
    logic        invertible;
  } inverse_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [m3i_pkg::THR_WIDTH-1:0] cfg_wdata_i;

  m3i_mat_if #(.DATA_WIDTH(DW)) mat ();
  m3i_inv_if #(.DATA_WIDTH(DW)) inv ();

  matrix3x3_inverse dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .mat_i      (mat),
    .inv_o      (inv)
  );

  logic [m3i_pkg::THR_WIDTH-1:0] threshold;
  inverse_t expected_inverses[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic elem_t saturated_quotient(wide_t num, wide_t det);
    wide_t scaled, q, lim;
    logic neg;
    scaled = num <<< (2 * FB);
    neg = scaled[255] ^ det[255];
    q = (scaled[255] ? -scaled : scaled) / (det[255] ? -det : det);
    lim = wide_t'(1) <<< (DW - 1);
    if (neg) begin
      if (q > lim) q = lim;
      return elem_t'(-q);
    end
    if (q > lim - 1) q = lim - 1;
    return elem_t'(q);
  endfunction

  function automatic inverse_t predict_inverse(elem_t m[9]);
    wide_t a, b, c, d, e, f, g, h, i, det, thr, mag;
    wide_t adj[9];
    inverse_t res;
    a = m[0]; b = m[1]; c = m[2]; d = m[3]; e = m[4];
    f = m[5]; g = m[6]; h = m[7]; i = m[8];
    adj[0] = e * i - f * h;
    adj[1] = c * h - b * i;
    adj[2] = b * f - c * e;
    adj[3] = f * g - d * i;
    adj[4] = a * i - c * g;
    adj[5] = c * d - a * f;
    adj[6] = d * h - e * g;
    adj[7] = b * g - a * h;
    adj[8] = a * e - b * d;
    det = a * adj[0] + b * adj[3] + c * adj[6];
    thr = wide_t'({1'b0, threshold}) <<< (2 * FB);
    mag = det[255] ? -det : det;
    res = '0;
    if (mag > thr) begin
      for (int k = 0; k < 9; k++) res.r[8 - k] = saturated_quotient(adj[k], det);
      res.invertible = 1'b1;
    end
    return res;
  endfunction

  task automatic send_matrix(elem_t m[9]);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      mat.valid <= 1'b0;
      @(posedge clk_i);
    end
    mat.valid <= 1'b1;
    {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22}
      <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    expected_inverses.push_back(predict_inverse(m));
    do @(posedge clk_i); while (!mat.ready);
  endtask

  task automatic drain_and_wait();
    mat.valid <= 1'b0;
    while (expected_inverses.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [m3i_pkg::THR_WIDTH-1:0] value);
    drain_and_wait();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = value;
  endtask

  function automatic elem_t random_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      2: return elem_t'($signed($urandom_range(0, 32'h0000_0100)) - 32'sh0000_0080);
      default: return $urandom_range(1) ? {1'b0, {(DW - 1){1'b1}}} : {1'b1, {(DW - 1){1'b0}}};
    endcase
  endfunction

  task automatic send_random(int count);
    elem_t m[9];
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(9);
      mode = mode < 2 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3;
      for (int k = 0; k < 9; k++) m[k] = random_elem($urandom_range(7) == 0 ? 3 - mode : mode);
      if ($urandom_range(9) == 0) for (int k = 0; k < 3; k++) m[6 + k] = m[3 + k];
      send_matrix(m);
    end
  endtask

  task automatic test_directed();
    elem_t one, mx, mn;
    elem_t m[9];
    one = elem_t'(1) <<< FB;
    mx = {1'b0, {(DW - 1){1'b1}}};
    mn = {1'b1, {(DW - 1){1'b0}}};
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};
    send_matrix(m);
    m = '{2 * one, 0, 0, 0, -4 * one, 0, 0, 0, one / 2};
    send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);
    m = '{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 9 * one};
    send_matrix(m);
    m = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};
    send_matrix(m);
    m = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};
    send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{mx, mn, mx, mn, mx, mn, mx, mn, 0};
    send_matrix(m);
    m = '{mn, mx, 1, -1, mn, mx, mx, 1, mn};
    send_matrix(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    send_matrix(m);
    m = '{0, one, 0, one, 0, 0, 0, 0, -one};
    send_matrix(m);
    m = '{256, 0, 0, 0, 256, 0, 0, 0, 256};
    send_matrix(m);
    m = '{one, 5, 0, 7, one, 0, 0, 0, 3};
    send_matrix(m);
  endtask

  task automatic test_thresholds();
    write_threshold('0);
    send_random(100);
    write_threshold({m3i_pkg::THR_WIDTH{1'b1}});
    send_random(60);
    write_threshold(31'h0001_0000);
    send_random(100);
    write_threshold(m3i_pkg::THR_RESET);
  endtask

  task automatic test_flow_control();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(400);
    send_idle_pct = 60; recv_stall_pct = 0;  send_random(300);
    drain_and_wait();
    send_idle_pct = 0;  recv_stall_pct = 60; send_random(300);
    send_idle_pct = 6;  recv_stall_pct = 6;  send_random(400);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    mat.valid = 1'b0;
    {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} = '0;
    inv.ready = 1'b0;
    threshold = m3i_pkg::THR_RESET;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_thresholds();
    test_flow_control();
    drain_and_wait();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      inv.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    inverse_t got, want;
    if (rst_ni && inv.valid && inv.ready) begin
      got.r = {inv.r00, inv.r01, inv.r02, inv.r10, inv.r11, inv.r12, inv.r20, inv.r21, inv.r22};
      got.invertible = inv.invertible;
      if (expected_inverses.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = expected_inverses.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (got.r[k] !== want.r[k]) begin
            $display("%0t: r%0d expected %h actual %h", $time, 8 - k, want.r[k], got.r[k]);
            mismatches++;
          end
        end
        if (got.invertible !== want.invertible) begin
          $display("%0t: invertible expected %b actual %b", $time,
                   want.invertible, got.invertible);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((mat.valid && mat.ready) || (inv.valid && inv.ready) || !rst_ni ||
        (expected_inverses.size() == 0 && !mat.valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
